// File: hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants of the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int WORD_BITS      = 16;
  localparam int SUM_BITS       = WORD_BITS + 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int PACK_BITS      = 8;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_FORMAT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_FORMAT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_MAX    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_MAX      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_WIDTH     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd5;

  // source kinds
  localparam logic [1:0] SRC_BITMAP = 2'd0;
  localparam logic [1:0] SRC_GRAY   = 2'd1;
  localparam logic [1:0] SRC_RGB    = 2'd2;
  localparam logic [1:0] SRC_PACKED = 2'd3;

  // destination kinds
  localparam logic [1:0] DST_BITMAP = 2'd0;
  localparam logic [1:0] DST_PACKED = 2'd1;
  localparam logic [1:0] DST_GRAY   = 2'd2;
  localparam logic [1:0] DST_RGB    = 2'd3;

  localparam int GRAY_THRESHOLD = 128;
  localparam int RGB_THRESHOLD  = 128 * 3;
  localparam logic [PACK_BITS-1:0] PACK_TOP = 8'h80;

  // divide by 3 as multiply by reciprocal, exact for sums below 2**19
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_BITS  = 19;
  localparam logic [RECIP_BITS-1:0] RECIP_THIRD = 19'd349526;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [WORD_BITS-1:0] sample_first;
    logic [WORD_BITS-1:0] sample_second;
    logic [WORD_BITS-1:0] sample_third;
  } pfc_pixel_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] out_first;
    logic [WORD_BITS-1:0] out_second;
    logic [WORD_BITS-1:0] out_third;
    logic                 row_end;
    logic                 image_end;
    logic                 error_flag;
  } pfc_result_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] first;
    logic [WORD_BITS-1:0] second;
    logic [WORD_BITS-1:0] third;
    logic [SUM_BITS-1:0]  sum;
    logic                 average;
    logic                 row_end;
    logic                 image_end;
    logic                 error_flag;
  } pfc_entry_t;

endpackage

// File: hdl/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Holds the configuration and position counters, classifies each pixel,
// assembles packed bitmap bytes and queues one entry per result.
// ----------------------------------------------------------------------------
module pfc_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int DIM_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pfc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pfc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 take,
  input  pfc_pkg::pfc_pixel_t                  pixel,
  output logic                                 push,
  output pfc_pkg::pfc_entry_t                  entry
);
  import pfc_pkg::*;

  logic [1:0]             source_format;
  logic [1:0]             dest_format;
  logic [SAMPLE_BITS-1:0] source_max;
  logic [SAMPLE_BITS-1:0] dest_max;
  logic [DIM_BITS-1:0]    row_width;
  logic [DIM_BITS-1:0]    image_height;

  logic [DIM_BITS-1:0]    column_count;
  logic [DIM_BITS-1:0]    row_count;
  logic [PACK_BITS-1:0]   packed_bits;
  logic [PACK_BITS-1:0]   packed_bits_next;

  logic [SAMPLE_BITS-1:0] a, b, c, expand;
  logic [SAMPLE_BITS+1:0] sum, rgb_half;
  logic [DIM_BITS:0]      col_inc, row_inc;
  logic                   last_col, last_row, bit0, set, emit, src_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= SRC_GRAY;
      dest_format   <= DST_PACKED;
      source_max    <= SAMPLE_BITS'(255);
      dest_max      <= SAMPLE_BITS'(255);
      row_width     <= DIM_BITS'(1);
      image_height  <= DIM_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SOURCE_FORMAT: source_format <= cfg_data[1:0];
        CFG_DEST_FORMAT:   dest_format   <= cfg_data[1:0];
        CFG_SOURCE_MAX:    source_max    <= cfg_data[SAMPLE_BITS-1:0];
        CFG_DEST_MAX:      dest_max      <= cfg_data[SAMPLE_BITS-1:0];
        CFG_ROW_WIDTH:     row_width     <= cfg_data[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign a        = pixel.sample_first[SAMPLE_BITS-1:0];
  assign b        = pixel.sample_second[SAMPLE_BITS-1:0];
  assign c        = pixel.sample_third[SAMPLE_BITS-1:0];
  assign bit0     = a[0];
  assign sum      = (SAMPLE_BITS+2)'(a) + (SAMPLE_BITS+2)'(b) + (SAMPLE_BITS+2)'(c);
  assign rgb_half = ((SAMPLE_BITS+2)'(source_max) + {1'b0, source_max, 1'b0}) >> 1;
  assign expand   = bit0 ? '0 : dest_max;
  assign src_err  = (source_format == SRC_PACKED);

  assign col_inc  = {1'b0, column_count} + (DIM_BITS+1)'(1);
  assign row_inc  = {1'b0, row_count} + (DIM_BITS+1)'(1);
  assign last_col = col_inc >= {1'b0, row_width};
  assign last_row = row_inc >= {1'b0, image_height};

  always_comb begin
    case (source_format)
      SRC_BITMAP: set = bit0;
      SRC_GRAY:   set = a <= (source_max >> 1);
      default:    set = sum <= rgb_half;
    endcase
    packed_bits_next = packed_bits | (set ? (PACK_TOP >> column_count[2:0]) : '0);
    emit = (dest_format != DST_PACKED) || (column_count[2:0] == 3'd7) || last_col;
  end

  always_comb begin
    entry            = '0;
    entry.sum        = SUM_BITS'(sum);
    entry.row_end    = last_col;
    entry.image_end  = last_col && last_row;
    if (src_err) begin
      entry            = '0;
      entry.error_flag = 1'b1;
    end else begin
      case (dest_format)
        DST_PACKED: entry.first = WORD_BITS'(packed_bits_next);
        DST_BITMAP: begin
          case (source_format)
            SRC_BITMAP: entry.first = WORD_BITS'(bit0);
            SRC_GRAY:   entry.first = WORD_BITS'(a < SAMPLE_BITS'(GRAY_THRESHOLD));
            default:    entry.first = WORD_BITS'(sum < (SAMPLE_BITS+2)'(RGB_THRESHOLD));
          endcase
        end
        DST_GRAY: begin
          case (source_format)
            SRC_BITMAP: entry.first = WORD_BITS'(expand);
            SRC_GRAY:   entry.first = WORD_BITS'(a);
            default:    entry.average = 1'b1;
          endcase
        end
        default: begin
          case (source_format)
            SRC_BITMAP: begin
              entry.first  = WORD_BITS'(expand);
              entry.second = WORD_BITS'(expand);
              entry.third  = WORD_BITS'(expand);
            end
            SRC_GRAY: begin
              entry.first  = WORD_BITS'(a);
              entry.second = WORD_BITS'(a);
              entry.third  = WORD_BITS'(a);
            end
            default: begin
              entry.first  = WORD_BITS'(a);
              entry.second = WORD_BITS'(b);
              entry.third  = WORD_BITS'(c);
            end
          endcase
        end
      endcase
    end
  end

  assign push = take && (src_err || emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      packed_bits  <= '0;
    end else if (take && !src_err) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_inc[DIM_BITS-1:0];
      end else begin
        column_count <= col_inc[DIM_BITS-1:0];
      end
      if (dest_format == DST_PACKED) begin
        packed_bits <= emit ? '0 : packed_bits_next;
      end
    end
  end

endmodule

// File: hdl/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue
// Small first-in first-out queue of classified entries between the front
// and back parts.
// ----------------------------------------------------------------------------
module pfc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pfc_pkg::pfc_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                nonempty,
  output pfc_pkg::pfc_entry_t head
);
  import pfc_pkg::*;

  pfc_entry_t                slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      do_push, do_pop;

  assign full     = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// Finishes each queued entry (rgb average by reciprocal multiply) and holds
// the result word in the output register until it is taken.
// ----------------------------------------------------------------------------
module pfc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 nonempty,
  input  pfc_pkg::pfc_entry_t  head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pfc_pkg::pfc_result_t result
);
  import pfc_pkg::*;

  logic [SUM_BITS+RECIP_BITS-1:0] product;
  logic [WORD_BITS-1:0]           third_of_sum;
  pfc_result_t                    result_next;

  assign product      = (SUM_BITS+RECIP_BITS)'(head.sum) * (SUM_BITS+RECIP_BITS)'(RECIP_THIRD);
  assign third_of_sum = product[RECIP_SHIFT +: WORD_BITS];
  assign pop          = nonempty && (!result_valid || !result_stall);

  always_comb begin
    result_next.out_first  = head.average ? third_of_sum : head.first;
    result_next.out_second = head.second;
    result_next.out_third  = head.third;
    result_next.row_end    = head.row_end;
    result_next.image_end  = head.image_end;
    result_next.error_flag = head.error_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

// File: hdl/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_converter
// Converts a raster stream of bitmap, gray or rgb pixels to bitmap, packed
// bitmap, gray or rgb words.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the input is not stalled and gives at most
// one result word per pixel; a packed bitmap word comes every 8 pixels or at
// row end. A pixel's result is registered first in the four-entry queue
// behind the classifying front, then in the output register of the back
// part. Input stall rises only when that queue is full, so a stalled output
// holds off the input after four more results have been queued.
// ----------------------------------------------------------------------------
module pixel_format_converter #(
  parameter int SAMPLE_BITS = 16,
  parameter int DIM_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pfc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  pfc_pkg::pfc_pixel_t                pixel,
  output logic                               result_valid,
  input  logic                               result_stall,
  output pfc_pkg::pfc_result_t               result
);
  import pfc_pkg::*;

  logic       take, push, pop, full, nonempty;
  pfc_entry_t push_entry, head;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = full;
  assign take        = pixel_valid && !pixel_stall;

  pfc_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DIM_BITS    (DIM_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .pixel     (pixel),
    .push      (push),
    .entry     (push_entry)
  );

  pfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .nonempty   (nonempty),
    .head       (head)
  );

  pfc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .nonempty     (nonempty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
